/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of i_clk, skipped while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that an event is followed in the next cycle by a condition.
`define ASSERT_NEXT(lbl, cause, effect, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cause) |=> (effect)) else $error(msg);

`endif

/* rtl/cpp_pkg.sv */
`timescale 1ns / 1ps

package cpp_pkg;

    localparam int MAX_CHARS = 100;
    localparam int VALUE_MAX = 65535;
    localparam int TBL_DEPTH = 128;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int DEC_BASE  = 10;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_CHAR  = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  ch;
        logic [6:0]  idx;
        logic [15:0] dflt;
    } t_item;

    typedef struct packed {
        logic              en;
        logic [TBL_AW-1:0] addr;
        logic [15:0]       data;
    } t_wr_req;

endpackage

/* rtl/cpp_table.sv */
`timescale 1ns / 1ps

module cpp_table (
    input  logic                   i_clk,
    input  cpp_pkg::t_wr_req       i_wr,
    input  logic                   i_rd_en,
    input  logic [6:0]             i_rd_idx,
    output logic [15:0]            o_rd_data
);

    logic [15:0]               r_mem [cpp_pkg::TBL_DEPTH];
    logic [15:0]               r_rd_data;
    logic [cpp_pkg::TBL_AW-1:0] w_rd_addr;

    assign w_rd_addr = i_rd_idx[cpp_pkg::TBL_AW-1:0];
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // forward a write landing on the same edge as the read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.en && i_wr.addr == w_rd_addr) begin
                r_rd_data <= i_wr.data;
            end else begin
                r_rd_data <= r_mem[w_rd_addr];
            end
        end
    end

endmodule

/* rtl/cpp_seg.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpp_seg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  cpp_pkg::t_item    i_item,
    input  logic [15:0]       i_rd_data,
    output cpp_pkg::t_wr_req  o_wr,
    output logic [15:0]       o_value,
    output logic [7:0]        o_count
);

    logic [6:0]  r_closed, n_closed;
    logic [15:0] r_acc, n_acc;
    logic        r_has_dig, n_has_dig;
    logic        r_ovf, n_ovf;
    logic [6:0]  r_chars, n_chars;

    logic        w_digit, w_semi, w_take;
    logic [7:0]  w_off;
    logic [19:0] w_next;
    logic [15:0] w_open, w_val;

    assign w_digit = i_item.ch >= cpp_pkg::CHAR_ZERO && i_item.ch <= cpp_pkg::CHAR_NINE;
    assign w_semi  = i_item.ch == cpp_pkg::CHAR_SEMI;
    assign w_off   = i_item.ch - cpp_pkg::CHAR_ZERO;
    assign w_next  = 20'(r_acc) * 20'(cpp_pkg::DEC_BASE) + 20'(w_off[3:0]);
    assign w_open  = (!r_has_dig || r_ovf) ? 16'd0 : r_acc;
    assign w_take  = i_adv && i_item.cmd == cpp_pkg::CMD_CHAR && (w_digit || w_semi)
                     && r_chars < 7'(cpp_pkg::MAX_CHARS);

    assign o_wr.en   = w_take && w_semi && int'(r_closed) < cpp_pkg::TBL_DEPTH;
    assign o_wr.addr = r_closed[cpp_pkg::TBL_AW-1:0];
    assign o_wr.data = w_open;

    always_comb begin
        w_val = 16'd0;
        if (i_item.idx < r_closed) begin
            if (int'(i_item.idx) < cpp_pkg::TBL_DEPTH) begin
                w_val = i_rd_data;
            end
        end else if (i_item.idx == r_closed) begin
            w_val = w_open;
        end
    end

    assign o_value = (w_val == 16'd0) ? i_item.dflt : w_val;
    assign o_count = 8'(r_closed) + 8'd1;

    always_comb begin
        n_closed  = r_closed;
        n_acc     = r_acc;
        n_has_dig = r_has_dig;
        n_ovf     = r_ovf;
        n_chars   = r_chars;
        if (i_adv && i_item.cmd == cpp_pkg::CMD_CLEAR) begin
            n_closed  = 7'd0;
            n_acc     = 16'd0;
            n_has_dig = 1'b0;
            n_ovf     = 1'b0;
            n_chars   = 7'd0;
        end else if (w_take) begin
            n_chars = r_chars + 7'd1;
            if (w_digit) begin
                n_has_dig = 1'b1;
                if (r_ovf || w_next > 20'(cpp_pkg::VALUE_MAX)) begin
                    n_ovf = 1'b1;
                end else begin
                    n_acc = w_next[15:0];
                end
            end else begin
                if (r_closed != 7'h7F) begin
                    n_closed = r_closed + 7'd1;
                end
                n_acc     = 16'd0;
                n_has_dig = 1'b0;
                n_ovf     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed  <= 7'd0;
            r_acc     <= 16'd0;
            r_has_dig <= 1'b0;
            r_ovf     <= 1'b0;
            r_chars   <= 7'd0;
        end else begin
            r_closed  <= n_closed;
            r_acc     <= n_acc;
            r_has_dig <= n_has_dig;
            r_ovf     <= n_ovf;
            r_chars   <= n_chars;
        end
    end

    `ASSERT_CLK(a_chars_cap, r_chars <= 7'(cpp_pkg::MAX_CHARS), "character count past limit")
    `ASSERT_CLK(a_ovf_digits, r_ovf |-> r_has_dig, "overflow flag without digits")
    `ASSERT_NEXT(a_clear, i_adv && i_item.cmd == cpp_pkg::CMD_CLEAR,
        r_closed == 7'd0 && r_chars == 7'd0 && r_acc == 16'd0, "clear left state behind")

endmodule

/* rtl/csi_parameter_parser_core.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel | Dir | Handshake           | Payload
// s       | in  | i_s_tvalid/o_s_tready | tuser: command; tdata: character, index, default
// m       | out | o_m_tvalid/i_m_tready | tdata: value, count
//
// One beat per cycle sustained in both directions while no held result blocks a query; a query
// result is valid on the master side after its beat passes the input register, then the result register.
// The parameter table read is registered off the input beat; a table write
// from the preceding beat is forwarded into that read.
// i_rst_n is synchronous, active low; it clears the segment state, not the table.
// A held result stalls a query that reaches it and every beat behind that query; other beats keep flowing.

module csi_parameter_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [7:0] character, [14:8] index, [30:15] default_value
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // [15:0] value, [23:16] count
);

    cpp_pkg::t_item   r_item;
    logic             r_s1_valid;
    logic             r_o_valid;
    logic [15:0]      r_o_value;
    logic [7:0]       r_o_count;

    logic             w_acc, w_adv, w_query;
    logic [15:0]      w_rd_data, w_value;
    logic [7:0]       w_count;
    cpp_pkg::t_wr_req w_wr;

    assign w_query    = r_item.cmd == cpp_pkg::CMD_QUERY;
    assign w_adv      = r_s1_valid && (!w_query || !r_o_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || w_adv;
    assign w_acc      = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {r_o_count, r_o_value};

    cpp_table u_table (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_en   (w_acc),
        .i_rd_idx  (i_s_tdata[14:8]),
        .o_rd_data (w_rd_data)
    );

    cpp_seg u_seg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_item    (r_item),
        .i_rd_data (w_rd_data),
        .o_wr      (w_wr),
        .o_value   (w_value),
        .o_count   (w_count)
    );

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item.cmd  <= cpp_pkg::t_cmd'(i_s_tuser);
            r_item.ch   <= i_s_tdata[7:0];
            r_item.idx  <= i_s_tdata[14:8];
            r_item.dflt <= i_s_tdata[30:15];
        end
        if (w_adv && w_query) begin
            r_o_value <= w_value;
            r_o_count <= w_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv && w_query) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    `ASSERT_CLK(a_stall_cause, !o_s_tready |-> r_s1_valid && r_o_valid && !i_m_tready && w_query,
        "input stalled without a blocked query")
    `ASSERT_CLK(a_count_nonzero, r_o_valid |-> r_o_count != 8'd0, "result count is zero")
    `ASSERT_NEXT(a_result_load, w_adv && w_query, r_o_valid, "query result not registered")

endmodule
